@@ src/rafp_pkg.sv @@
// Shared types, constants and helper functions for the RFID ASCII frame parser.
package rafp_pkg;

	localparam int TAG_CHARS   = 10;
	localparam int FRAME_CHARS = TAG_CHARS + 2;
	localparam int TAG_W       = 4 * TAG_CHARS;
	localparam int POS_W       = $clog2(FRAME_CHARS + 1);
	localparam int CSUM_BYTES  = (TAG_CHARS + 1) / 2;
	localparam int PAD_W       = 8 * CSUM_BYTES;
	localparam int TAG_OUT_W   = 40;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [7:0] STX_BYTE = 8'h02;
	localparam logic [7:0] ETX_BYTE = 8'h03;

	localparam logic [1:0] EV_FOUND = 2'd0;
	localparam logic [1:0] EV_ERROR = 2'd1;
	localparam logic [1:0] EV_GONE  = 2'd2;

	typedef enum logic [1:0] {
		CLS_CHAR = 2'd0,
		CLS_STX  = 2'd1,
		CLS_ETX  = 2'd2,
		CLS_TICK = 2'd3
	} item_cls_t;

	typedef struct packed {
		item_cls_t  cls;
		logic [3:0] digit;
		logic       hex_ok;
	} item_t;

	function automatic logic [7:0] tag_xor(input logic [TAG_W-1:0] tag);
		logic [PAD_W-1:0] padded;
		logic [7:0]       acc;
		padded = PAD_W'(tag);
		acc = 8'h00;
		for (int i = 0; i < CSUM_BYTES; i++) begin
			acc = acc ^ padded[8*i +: 8];
		end
		return acc;
	endfunction

	function automatic logic [TAG_OUT_W-1:0] tag_out(input logic [TAG_W-1:0] tag);
		logic [TAG_W+TAG_OUT_W-1:0] ext;
		ext = {{TAG_OUT_W{1'b0}}, tag};
		return ext[TAG_OUT_W-1:0];
	endfunction

endpackage

@@ src/rafp_front.sv @@
// Input stage: classifies each beat, decodes hex digits and queues the result.
module rafp_front import rafp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       kind,
	input  logic [7:0] rx_byte,
	output logic       q_valid,
	output item_t      q_item,
	input  logic       q_pop
);

	item_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  count_q;
	item_t              cls_item;
	logic               push;

	always_comb begin
		cls_item.digit  = 4'h0;
		cls_item.hex_ok = 1'b0;
		if (kind) begin
			cls_item.cls = CLS_TICK;
		end else if (rx_byte == STX_BYTE) begin
			cls_item.cls = CLS_STX;
		end else if (rx_byte == ETX_BYTE) begin
			cls_item.cls = CLS_ETX;
		end else begin
			cls_item.cls = CLS_CHAR;
			case (rx_byte) inside
				[8'h30:8'h39]: begin
					cls_item.digit  = rx_byte[3:0];
					cls_item.hex_ok = 1'b1;
				end
				[8'h41:8'h46], [8'h61:8'h66]: begin
					cls_item.digit  = rx_byte[3:0] + 4'd9;
					cls_item.hex_ok = 1'b1;
				end
				default: begin
					cls_item.digit  = 4'h0;
					cls_item.hex_ok = 1'b0;
				end
			endcase
		end
	end

	assign in_stall = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign push     = in_valid && !in_stall;
	assign q_valid  = (count_q != '0);
	assign q_item   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= cls_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (q_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !q_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && q_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ src/rafp_back.sv @@
// Frame state, checksum test, repeat filter and the output register.
module rafp_back import rafp_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_valid,
	input  item_t                q_item,
	output logic                 q_pop,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [1:0]           event_res,
	output logic [TAG_OUT_W-1:0] tag_value
);

	logic [POS_W-1:0]     pos_q;
	logic [TAG_W-1:0]     tag_q;
	logic [7:0]           csum_q;
	logic                 bad_q;
	logic [TAG_W-1:0]     last_q;
	logic                 last_v_q;
	logic                 out_valid_q;
	logic [1:0]           event_q;
	logic [TAG_OUT_W-1:0] tag_out_q;
	logic                 frame_bad;
	logic                 repeat_tag;
	logic                 emit;

	assign q_pop      = q_valid && (!out_valid_q || !out_stall);
	assign frame_bad  = (pos_q != POS_W'(FRAME_CHARS)) || bad_q || (tag_xor(tag_q) != csum_q);
	assign repeat_tag = last_v_q && (last_q == tag_q);
	assign emit       = q_pop && (((q_item.cls == CLS_TICK) && (pos_q != '0)) ||
	                              ((q_item.cls == CLS_ETX) && (frame_bad || !repeat_tag)));

	assign out_valid = out_valid_q;
	assign event_res = event_q;
	assign tag_value = tag_out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			tag_q       <= '0;
			csum_q      <= '0;
			bad_q       <= 1'b0;
			last_q      <= '0;
			last_v_q    <= 1'b0;
			out_valid_q <= 1'b0;
			event_q     <= EV_FOUND;
			tag_out_q   <= '0;
		end else begin
			out_valid_q <= emit || (out_valid_q && out_stall);
			if (q_pop) begin
				case (q_item.cls)
					CLS_TICK: begin
						if (pos_q != '0) begin
							event_q     <= EV_GONE;
							tag_out_q   <= tag_out(tag_q);
							pos_q       <= '0;
							tag_q       <= '0;
							csum_q      <= '0;
							bad_q       <= 1'b0;
							last_q      <= '0;
							last_v_q    <= 1'b0;
						end
					end
					CLS_STX: begin
						pos_q  <= '0;
						tag_q  <= '0;
						csum_q <= '0;
						bad_q  <= 1'b0;
					end
					CLS_ETX: begin
						if (frame_bad) begin
							event_q     <= EV_ERROR;
							tag_out_q   <= tag_out(tag_q);
						end else if (!repeat_tag) begin
							event_q     <= EV_FOUND;
							tag_out_q   <= tag_out(tag_q);
							last_q      <= tag_q;
							last_v_q    <= 1'b1;
						end
					end
					default: begin
						if (pos_q < POS_W'(FRAME_CHARS)) begin
							if (!q_item.hex_ok) begin
								bad_q <= 1'b1;
							end
							if (pos_q < POS_W'(TAG_CHARS)) begin
								tag_q <= {tag_q[TAG_W-5:0], q_item.digit};
							end else begin
								csum_q <= {csum_q[3:0], q_item.digit};
							end
							pos_q <= pos_q + 1'b1;
						end
					end
				endcase
			end
		end
	end

endmodule

@@ src/rfid_ascii_frame_parser.sv @@
// Top level of the RFID ASCII frame parser: input stage, queue and frame logic.
// An accepted beat is written into the front queue, and its result is held in the back stage's output register.
// Throughput: one beat per cycle while out_stall is low, set by the frame update in the back stage.
// A two-entry queue decouples input acceptance from output stalls.
// Asynchronous reset clears the queue, the frame state, the last reported tag
// and the output register.
module rfid_ascii_frame_parser import rafp_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 kind,
	input  logic [7:0]           rx_byte,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [1:0]           event_res,
	output logic [TAG_OUT_W-1:0] tag_value
);

	logic  q_valid;
	logic  q_pop;
	item_t q_item;

	rafp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.kind     (kind),
		.rx_byte  (rx_byte),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_pop    (q_pop)
	);

	rafp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.event_res (event_res),
		.tag_value (tag_value)
	);

endmodule

@@ src/rafp_checker.sv @@
// Port-level assertions for the RFID ASCII frame parser and their bind.
module rafp_checker import rafp_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_stall,
	input logic                 kind,
	input logic [7:0]           rx_byte,
	input logic                 out_valid,
	input logic                 out_stall,
	input logic [1:0]           event_res,
	input logic [TAG_OUT_W-1:0] tag_value
);

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(kind) && $stable(rx_byte))
		else $error("Stalled input beat changed.");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(event_res) && $stable(tag_value))
		else $error("Stalled output beat changed.");

	a_event_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (event_res == EV_FOUND || event_res == EV_ERROR || event_res == EV_GONE))
		else $error("Output event code out of range.");

	a_no_repeat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && event_res == EV_FOUND |=>
			!(out_valid && event_res == EV_FOUND && tag_value == $past(tag_value)))
		else $error("Same tag reported as found twice in a row.");

	a_reset_idle: assert property (@(posedge clk)
		$rose(arst_n) |-> !out_valid)
		else $error("Output beat present right after reset.");

endmodule

bind rfid_ascii_frame_parser rafp_checker u_rafp_checker (.*);

@@ dv/rfid_ascii_frame_parser_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the RFID ASCII frame parser, with its own frame and event predictor.
module rfid_ascii_frame_parser_tb;
	import rafp_pkg::*;

	localparam bit KIND_BYTE   = 1'b0;
	localparam bit KIND_TICK   = 1'b1;
	localparam int QUIET_LIMIT = 4000;
	localparam int PHASE_BEATS = 375;
	localparam int REPORT_CAP  = 100;

	typedef struct {
		logic [1:0]           ev;
		logic [TAG_OUT_W-1:0] tag;
	} reader_event_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic                 kind = 1'b0;
	logic [7:0]           rx_byte = 8'h00;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [1:0]           event_res;
	logic [TAG_OUT_W-1:0] tag_value;

	int unsigned      frame_pos = 0;
	logic [TAG_W-1:0] tag_digits = '0;
	logic [7:0]       csum_digits = 8'h00;
	bit               frame_malformed = 1'b0;
	logic [TAG_W-1:0] last_reported = '0;
	bit               last_reported_ok = 1'b0;

	reader_event_t    expected_events[$];
	int               mismatch_count = 0;
	int               beats_sent = 0;
	int               quiet_cycles = 0;
	int               send_idle_pct = 0;
	int               recv_idle_pct = 0;
	logic [TAG_W-1:0] recent_tag = '0;

	rfid_ascii_frame_parser u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.kind      (kind),
		.rx_byte   (rx_byte),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.event_res (event_res),
		.tag_value (tag_value)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	function automatic logic [3:0] hex_value(input logic [7:0] c, output bit ok);
		ok = 1'b1;
		if (c >= 8'h30 && c <= 8'h39) begin
			return 4'(c - 8'h30);
		end
		if (c >= 8'h41 && c <= 8'h46) begin
			return 4'(c - 8'h41 + 8'd10);
		end
		if (c >= 8'h61 && c <= 8'h66) begin
			return 4'(c - 8'h61 + 8'd10);
		end
		ok = 1'b0;
		return 4'h0;
	endfunction

	function automatic logic [7:0] xor_of_pairs(input logic [TAG_W-1:0] t);
		logic [TAG_W+7:0] padded;
		logic [7:0]       acc;
		padded = {8'h00, t};
		acc = 8'h00;
		for (int i = 0; i < (TAG_CHARS + 1) / 2; i++) begin
			acc ^= padded[8*i +: 8];
		end
		return acc;
	endfunction

	function automatic void clear_frame();
		frame_pos = 0;
		tag_digits = '0;
		csum_digits = 8'h00;
		frame_malformed = 1'b0;
	endfunction

	function automatic void push_event(input logic [1:0] ev);
		expected_events.push_back('{ev, TAG_OUT_W'(tag_digits)});
	endfunction

	function automatic void predict_reader_event(input bit tick, input logic [7:0] b);
		bit         ok;
		logic [3:0] d;
		if (tick) begin
			if (frame_pos != 0) begin
				push_event(EV_GONE);
				clear_frame();
				last_reported = '0;
				last_reported_ok = 1'b0;
			end
		end else if (b == STX_BYTE) begin
			clear_frame();
		end else if (b == ETX_BYTE) begin
			if (frame_pos != FRAME_CHARS || frame_malformed ||
			    xor_of_pairs(tag_digits) != csum_digits) begin
				push_event(EV_ERROR);
			end else if (!(last_reported_ok && last_reported == tag_digits)) begin
				last_reported = tag_digits;
				last_reported_ok = 1'b1;
				push_event(EV_FOUND);
			end
		end else if (frame_pos < FRAME_CHARS) begin
			d = hex_value(b, ok);
			if (!ok) begin
				frame_malformed = 1'b1;
			end
			if (frame_pos < TAG_CHARS) begin
				tag_digits = {tag_digits[TAG_W-5:0], d};
			end else begin
				csum_digits = {csum_digits[3:0], d};
			end
			frame_pos++;
		end
	endfunction

	function automatic logic [7:0] ascii_digit(input logic [3:0] d, input bit lower);
		if (d < 4'd10) begin
			return 8'h30 + d;
		end
		return (lower ? 8'h61 : 8'h41) + d - 8'd10;
	endfunction

	function automatic logic [7:0] non_hex_byte();
		logic [7:0] c;
		bit         ok;
		do begin
			c = 8'($urandom_range(255));
			void'(hex_value(c, ok));
		end while (ok || c == STX_BYTE || c == ETX_BYTE);
		return c;
	endfunction

	function automatic logic [TAG_W-1:0] random_tag();
		logic [TAG_W-1:0] t;
		int               pick;
		pick = $urandom_range(99);
		if (pick < 30) begin
			return recent_tag;
		end
		if (pick < 35) begin
			return '0;
		end
		if (pick < 40) begin
			return '1;
		end
		for (int i = 0; i < TAG_CHARS; i++) begin
			t[4*i +: 4] = 4'($urandom_range(15));
		end
		return t;
	endfunction

	task automatic report_mismatch(input string msg);
		if (mismatch_count < REPORT_CAP) begin
			$display("[%0t] mismatch: %s", $realtime, msg);
		end
		mismatch_count++;
	endtask

	task automatic send_beat(input bit tick, input logic [7:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= tick;
		rx_byte <= b;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		predict_reader_event(tick, b);
		beats_sent++;
	endtask

	// Sends STX, the first chars characters of tag and checksum, extra trailing digits and,
	// if close is set, ETX. A character at bad_at is replaced by a non-hex byte.
	task automatic send_frame(input logic [TAG_W-1:0] tag, input logic [7:0] csum_flip,
		input int bad_at, input int chars, input int extra, input bit close);
		logic [TAG_W+7:0] digits;
		logic [3:0]       d;
		logic [7:0]       c;
		digits = {tag, xor_of_pairs(tag) ^ csum_flip};
		send_beat(KIND_BYTE, STX_BYTE);
		for (int i = 0; i < chars + extra; i++) begin
			if (i < FRAME_CHARS) begin
				d = digits[4*(FRAME_CHARS-1-i) +: 4];
			end else begin
				d = 4'($urandom_range(15));
			end
			c = ascii_digit(d, $urandom_range(1));
			if (i == bad_at) begin
				c = non_hex_byte();
			end
			send_beat(KIND_BYTE, c);
		end
		if (close) begin
			send_beat(KIND_BYTE, ETX_BYTE);
		end
	endtask

	task automatic test_frame_edge_cases();
		send_frame('1, 8'h00, -1, FRAME_CHARS, 1, 1'b1);
		send_beat(KIND_BYTE, ETX_BYTE);
		send_beat(KIND_TICK, 8'hFF);
		send_beat(KIND_TICK, 8'h00);
		send_beat(KIND_BYTE, ETX_BYTE);
		send_frame(random_tag(), 8'h00, 1, 3, 0, 1'b1);
	endtask

	task automatic test_random_traffic(input int beats);
		int               start;
		int               pick;
		logic [TAG_W-1:0] tag;
		start = beats_sent;
		while (beats_sent - start < beats) begin
			pick = $urandom_range(99);
			if (pick < 70) begin
				tag = random_tag();
				recent_tag = tag;
				pick = $urandom_range(99);
				if (pick < 10) begin
					send_frame(tag, 8'($urandom_range(255, 1)), -1, FRAME_CHARS, 0, 1'b1);
				end else if (pick < 18) begin
					send_frame(tag, 8'h00, $urandom_range(FRAME_CHARS - 1), FRAME_CHARS, 0, 1'b1);
				end else if (pick < 26) begin
					send_frame(tag, 8'h00, -1, $urandom_range(FRAME_CHARS - 1), 0, 1'b1);
				end else if (pick < 36) begin
					send_frame(tag, 8'h00, -1, FRAME_CHARS, $urandom_range(4, 1), 1'b1);
				end else if (pick < 42) begin
					send_frame(tag, 8'h00, -1, $urandom_range(FRAME_CHARS), 0, 1'b0);
				end else begin
					send_frame(tag, 8'h00, -1, FRAME_CHARS, 0, 1'b1);
				end
				if ($urandom_range(99) < 8) begin
					send_beat(KIND_BYTE, ETX_BYTE);
				end
				if ($urandom_range(99) < 12) begin
					send_beat(KIND_TICK, 8'($urandom));
				end
			end else if (pick < 80) begin
				send_beat(KIND_TICK, 8'($urandom));
			end else if (pick < 88) begin
				send_beat(KIND_BYTE, $urandom_range(1) ? STX_BYTE : ETX_BYTE);
			end else begin
				send_beat(KIND_BYTE, 8'($urandom));
			end
		end
	endtask

	always @(posedge clk) begin
		reader_event_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_events.size() == 0) begin
				report_mismatch($sformatf("unexpected event %0d tag %h", event_res, tag_value));
			end else begin
				want = expected_events.pop_front();
				if (event_res !== want.ev) begin
					report_mismatch($sformatf("event %0d, expected %0d", event_res, want.ev));
				end
				if (tag_value !== want.tag) begin
					report_mismatch($sformatf("tag %h, expected %h", tag_value, want.tag));
				end
			end
		end
		out_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_idle_pct = 16;
		recv_idle_pct = 53;
		test_frame_edge_cases();
		test_random_traffic(PHASE_BEATS);
		send_idle_pct = 53;
		recv_idle_pct = 16;
		test_random_traffic(PHASE_BEATS);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_traffic(PHASE_BEATS);
		in_valid <= 1'b0;
		while (expected_events.size() != 0) begin
			@(posedge clk);
		end
		repeat (8) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
src/rafp_pkg.sv
src/rafp_front.sv
src/rafp_back.sv
src/rfid_ascii_frame_parser.sv
src/rafp_checker.sv
dv/rfid_ascii_frame_parser_tb.sv
